// ===== hdl/ffsa_pkg.sv =====
// Shared types, codes and field widths for the first-fit segment allocator.
package ffsa_pkg;

  // Field widths of the input and result items
  localparam int OP_W     = 2;
  localparam int SIZE_W   = 13;
  localparam int STATUS_W = 2;
  localparam int START_W  = 12;
  localparam int SEGS_W   = 7;

  // Defaults for the top-level parameters
  localparam int MAX_SEGMENTS_DEF = 64;
  localparam int MEM_UNITS_DEF    = 4096;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BADSIZE = 2'd3;

  // Commands broadcast to the cell row
  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_NONE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXACT  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPLIT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MERGE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size;
    logic              mark_free;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [START_W-1:0]  block_start;
    logic [SEGS_W-1:0]   segments_used;
  } out_item_t;

  typedef struct packed {
    logic [CMD_W-1:0] code;
    logic             mark_free;
  } cell_cmd_t;

endpackage

// ===== hdl/first_fit_segment_allocator_core.sv =====
// Top level of the first-fit segment allocator: control, status and the cell row.
//
// For each item, at the transfer every cell compares its own
// segment with the requested size, and in the following cycle (busy high) the
// first-fit pick ripples through the chain of MAX_SEGMENTS cells and the table
// is updated (split rests shift-inserted one cell up, appends and merges
// written in place). The result is shown for one cycle on out_valid/out_data in
// the cycle after that, and start may already carry the next item in that
// cycle. The receiver cannot hold results off. The found chain across all cells
// is the path that sets the clock rate.
module first_fit_segment_allocator_core
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
  parameter int MEM_UNITS    = MEM_UNITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int SZ_W  = ($clog2(MEM_UNITS + 1) > SIZE_W) ? $clog2(MEM_UNITS + 1) : SIZE_W;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [SZ_W-1:0]  MEM_LIM = SZ_W'(MEM_UNITS);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic             state_r, state_nxt;
  in_item_t         req_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SZ_W-1:0]  layout_r, layout_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             accept;
  logic [SZ_W-1:0]  cell_size, req_sz;
  cell_cmd_t        cmd;
  logic [STATUS_W-1:0] status;
  logic [SZ_W-1:0]  res_start;

  logic [SZ_W-1:0]  pick_any;
  logic             exact_any, last_free_any, any_hit;
  logic             bad_alloc, bad_append, tbl_full;

  logic             found_w  [MAX_SEGMENTS];
  logic             first_w  [MAX_SEGMENTS];
  logic [SZ_W-1:0]  start_w  [MAX_SEGMENTS];
  logic [SZ_W-1:0]  size_w   [MAX_SEGMENTS];
  logic             free_w   [MAX_SEGMENTS];
  logic [SZ_W-1:0]  pick_w   [MAX_SEGMENTS];
  logic             exact_w  [MAX_SEGMENTS];
  logic             lastf_w  [MAX_SEGMENTS];
  logic [MAX_SEGMENTS-1:0] first_vec;

  assign busy      = state_r == S_RUN;
  assign accept    = start & ~busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign req_sz    = SZ_W'(req_r.size);
  assign cell_size = busy ? req_sz : SZ_W'(in_data.size);

  // cell row
  for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
    if (g == 0) begin : g_head
      ffsa_cell #(.IDX(g), .SZ_W(SZ_W), .CNT_W(CNT_W)) u_cell (
        .clk(clk), .load(accept), .cmd(cmd), .req_size(cell_size),
        .app_start(layout_r), .count(count_r),
        .prev_found(1'b0), .prev_first(1'b0),
        .prev_start('0), .prev_size('0), .prev_free(1'b0),
        .found(found_w[g]), .first(first_w[g]),
        .seg_start(start_w[g]), .seg_size(size_w[g]), .seg_free(free_w[g]),
        .pick_start(pick_w[g]), .exact_hit(exact_w[g]), .last_free(lastf_w[g])
      );
    end else begin : g_body
      ffsa_cell #(.IDX(g), .SZ_W(SZ_W), .CNT_W(CNT_W)) u_cell (
        .clk(clk), .load(accept), .cmd(cmd), .req_size(cell_size),
        .app_start(layout_r), .count(count_r),
        .prev_found(found_w[g-1]), .prev_first(first_w[g-1]),
        .prev_start(start_w[g-1]), .prev_size(size_w[g-1]), .prev_free(free_w[g-1]),
        .found(found_w[g]), .first(first_w[g]),
        .seg_start(start_w[g]), .seg_size(size_w[g]), .seg_free(free_w[g]),
        .pick_start(pick_w[g]), .exact_hit(exact_w[g]), .last_free(lastf_w[g])
      );
    end
  end

  // gather per-cell flags
  always_comb begin
    pick_any      = '0;
    exact_any     = 1'b0;
    last_free_any = 1'b0;
    for (int i = 0; i < MAX_SEGMENTS; i++) begin
      pick_any      = pick_any | pick_w[i];
      exact_any     = exact_any | exact_w[i];
      last_free_any = last_free_any | lastf_w[i];
      first_vec[i]  = first_w[i];
    end
  end
  assign any_hit = found_w[MAX_SEGMENTS-1];

  // size checks
  assign bad_alloc  = (req_sz == '0) || (req_sz > MEM_LIM);
  assign bad_append = bad_alloc ||
                      (({1'b0, layout_r} + {1'b0, req_sz}) > {1'b0, MEM_LIM});
  assign tbl_full   = count_r == CNT_MAX;

  // commit decision
  always_comb begin
    cmd.code      = CMD_NONE;
    cmd.mark_free = req_r.mark_free;
    count_nxt     = count_r;
    layout_nxt    = layout_r;
    status        = ST_OK;
    res_start     = '0;
    if (busy) begin
      unique case (req_r.op)
        OP_CLEAR: begin
          count_nxt  = '0;
          layout_nxt = '0;
        end
        OP_APPEND: begin
          priority if (bad_append) begin
            status = ST_BADSIZE;
          end else if ((count_r != '0) && req_r.mark_free && last_free_any) begin
            cmd.code   = CMD_MERGE;
            res_start  = layout_r;
            layout_nxt = layout_r + req_sz;
          end else if (tbl_full) begin
            status = ST_FULL;
          end else begin
            cmd.code   = CMD_APPEND;
            res_start  = layout_r;
            layout_nxt = layout_r + req_sz;
            count_nxt  = count_r + CNT_W'(1);
          end
        end
        OP_ALLOC: begin
          priority if (bad_alloc) begin
            status = ST_BADSIZE;
          end else if (!any_hit) begin
            status = ST_NOFIT;
          end else if (exact_any) begin
            cmd.code  = CMD_EXACT;
            res_start = pick_any;
          end else if (tbl_full) begin
            status = ST_FULL;
          end else begin
            cmd.code  = CMD_SPLIT;
            res_start = pick_any;
            count_nxt = count_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // sequencing and result register
  always_comb begin
    state_nxt                  = accept ? S_RUN : S_IDLE;
    out_valid_nxt              = busy;
    out_data_nxt.status        = status;
    out_data_nxt.block_start   = START_W'(res_start);
    out_data_nxt.segments_used = SEGS_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      layout_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      layout_r    <= layout_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_r <= in_data;
    out_data_r <= out_data_nxt;
  end

  // checks
  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy) else $error("busy held longer than one cycle");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid) else $error("result strobe missing");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX) else $error("segment count beyond table depth");

  a_layout_bound: assert property (@(posedge clk) disable iff (!rst_n)
    layout_r <= MEM_LIM) else $error("layout end beyond memory");

  a_single_pick: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $onehot0(first_vec)) else $error("more than one first-fit cell");

endmodule

// ===== hdl/ffsa_cell.sv =====
// One table entry of the allocator: holds a segment and shifts with its neighbor.
module ffsa_cell
  import ffsa_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int SZ_W  = 13,
  parameter int CNT_W = 7
) (
  input  logic             clk,
  input  logic             load,        // item transfer: evaluate fit
  input  cell_cmd_t        cmd,         // update applied in the commit cycle
  input  logic [SZ_W-1:0]  req_size,
  input  logic [SZ_W-1:0]  app_start,
  input  logic [CNT_W-1:0] count,
  input  logic             prev_found,
  input  logic             prev_first,
  input  logic [SZ_W-1:0]  prev_start,
  input  logic [SZ_W-1:0]  prev_size,
  input  logic             prev_free,
  output logic             found,
  output logic             first,
  output logic [SZ_W-1:0]  seg_start,
  output logic [SZ_W-1:0]  seg_size,
  output logic             seg_free,
  output logic [SZ_W-1:0]  pick_start,
  output logic             exact_hit,
  output logic             last_free
);

  logic [SZ_W-1:0] start_r, start_nxt;
  logic [SZ_W-1:0] size_r, size_nxt;
  logic            free_r, free_nxt;
  logic            hit_r, eq_r;
  logic            active, is_last, is_new;

  assign active  = CNT_W'(IDX) < count;
  assign is_last = CNT_W'(IDX + 1) == count;
  assign is_new  = CNT_W'(IDX) == count;

  // first-fit chain: first hit has no hit ahead of it
  assign first = hit_r & ~prev_found;
  assign found = prev_found | hit_r;

  assign seg_start  = start_r;
  assign seg_size   = size_r;
  assign seg_free   = free_r;
  assign pick_start = first ? start_r : '0;
  assign exact_hit  = first & eq_r;
  assign last_free  = is_last & free_r;

  // entry update
  always_comb begin
    start_nxt = start_r;
    size_nxt  = size_r;
    free_nxt  = free_r;
    unique case (cmd.code)
      CMD_EXACT: begin
        if (first) free_nxt = 1'b0;
      end
      CMD_SPLIT: begin
        priority if (first) begin
          size_nxt = req_size;
          free_nxt = 1'b0;
        end else if (prev_first) begin
          // free rest of the split segment
          start_nxt = prev_start + req_size;
          size_nxt  = prev_size - req_size;
          free_nxt  = 1'b1;
        end else if (prev_found) begin
          // shift up by one entry
          start_nxt = prev_start;
          size_nxt  = prev_size;
          free_nxt  = prev_free;
        end
      end
      CMD_MERGE: begin
        if (is_last) size_nxt = size_r + req_size;
      end
      CMD_APPEND: begin
        if (is_new) begin
          start_nxt = app_start;
          size_nxt  = req_size;
          free_nxt  = cmd.mark_free;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    size_r  <= size_nxt;
    free_r  <= free_nxt;
    if (load) begin
      hit_r <= active & free_r & (size_r >= req_size);
      eq_r  <= size_r == req_size;
    end
  end

endmodule
